[rtl/format_string_tokenizer_assert.svh]
// Assertion macros shared by the tokenizer checker.
`ifndef FORMAT_STRING_TOKENIZER_ASSERT_SVH
`define FORMAT_STRING_TOKENIZER_ASSERT_SVH

// Clocked assertion, ignored while reset is asserted.
`define FST_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define FST_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/fst_pkg.sv]
// ----------------------------------------------------------------------------
// fst_pkg
// Types, codes and sizes shared by the format string tokenizer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package fst_pkg;

  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned POS_W     = 16;  // position counter, wraps
  localparam int unsigned ERR_POS_W = 16;  // reported position field
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic [1:0] {
    CFG_ESCAPE  = 2'd0,
    CFG_MARKER  = 2'd1,
    CFG_OPEN    = 2'd2,
    CFG_CLOSE   = 2'd3
  } cfg_idx_e;

  localparam logic [CHAR_W-1:0] RST_ESCAPE = 8'd92;
  localparam logic [CHAR_W-1:0] RST_MARKER = 8'd37;
  localparam logic [CHAR_W-1:0] RST_OPEN   = 8'd123;
  localparam logic [CHAR_W-1:0] RST_CLOSE  = 8'd125;
  localparam logic [CHAR_W-1:0] NUL_CHAR   = 8'd0;

  // Character class, decided in the front part.
  typedef enum logic [2:0] {
    CLS_OTHER = 3'd0,
    CLS_ESC   = 3'd1,
    CLS_MARK  = 3'd2,
    CLS_OPEN  = 3'd3,
    CLS_CLOSE = 3'd4,
    CLS_END   = 3'd5
  } cls_e;

  typedef enum logic [2:0] {
    KIND_TEXT      = 3'd0,
    KIND_OPT       = 3'd1,
    KIND_SEG_END   = 3'd2,
    KIND_ENTRY_END = 3'd3,
    KIND_ERROR     = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE  = 3'd0,
    ERR_ESC   = 3'd1,
    ERR_MARK  = 3'd2,
    ERR_OPEN  = 3'd3,
    ERR_CLOSE = 3'd4,
    ERR_CHAR  = 3'd5,
    ERR_END   = 3'd6
  } err_e;

  typedef struct packed {
    cls_e              cls;
    logic [CHAR_W-1:0] ch;
  } tok_t;

  typedef struct packed {
    logic [ERR_POS_W-1:0] pos;
    err_e                 code;
    logic [CHAR_W-1:0]    ch;
    kind_e                kind;
  } res_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 32;

endpackage

`default_nettype wire

[rtl/fst_fifo.sv]
// ----------------------------------------------------------------------------
// fst_fifo
// Short token queue between the classifying front and the parsing back.
// ----------------------------------------------------------------------------
`default_nettype none

module fst_fifo
  import fst_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  tok_t            push_tok_i,
  input  wire logic       pop_i,
  output tok_t            pop_tok_o,
  output fifo_stat_t      stat_o
);

  tok_t               mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_AW:0]   cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q + FIFO_AW'(push_i);
    rd_ptr_d = rd_ptr_q + FIFO_AW'(pop_i);
    cnt_d    = cnt_q + (FIFO_AW+1)'(push_i) - (FIFO_AW+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_tok_i;
    end
  end

  assign pop_tok_o    = mem_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign stat_o.empty = (cnt_q == '0);

endmodule

`default_nettype wire

[rtl/fst_front.sv]
// ----------------------------------------------------------------------------
// fst_front
// Input stage: holds the special characters and classifies each item.
// ----------------------------------------------------------------------------
`default_nettype none

module fst_front
  import fst_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  cfg_idx_e               cfg_idx_i,
  input  wire logic [CHAR_W-1:0] cfg_data_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              in_end_i,
  input  wire logic [CHAR_W-1:0] in_char_i,
  input  fifo_stat_t             fifo_stat_i,
  output logic                   push_o,
  output tok_t                   push_tok_o
);

  logic [CHAR_W-1:0] esc_q, mark_q, open_q, close_q;
  logic              vld_q, vld_d;
  tok_t              tok_q;
  tok_t              tok_d;
  logic              accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q   <= RST_ESCAPE;
      mark_q  <= RST_MARKER;
      open_q  <= RST_OPEN;
      close_q <= RST_CLOSE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ESCAPE: esc_q   <= cfg_data_i;
        CFG_MARKER: mark_q  <= cfg_data_i;
        CFG_OPEN:   open_q  <= cfg_data_i;
        CFG_CLOSE:  close_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Priority: end of string, escape, marker, options open, options close.
  always_comb begin
    tok_d.ch = in_char_i;
    if (in_end_i)                  tok_d.cls = CLS_END;
    else if (in_char_i == esc_q)   tok_d.cls = CLS_ESC;
    else if (in_char_i == mark_q)  tok_d.cls = CLS_MARK;
    else if (in_char_i == open_q)  tok_d.cls = CLS_OPEN;
    else if (in_char_i == close_q) tok_d.cls = CLS_CLOSE;
    else                           tok_d.cls = CLS_OTHER;
  end

  assign push_o     = vld_q && !fifo_stat_i.full;
  assign in_ready_o = !vld_q || push_o;
  assign accept     = in_valid_i && in_ready_o;
  assign push_tok_o = tok_q;

  always_comb begin
    vld_d = vld_q;
    if (accept)      vld_d = 1'b1;
    else if (push_o) vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= 1'b0;
    else         vld_q <= vld_d;
  end

  always_ff @(posedge clk_i) begin
    if (accept) tok_q <= tok_d;
  end

endmodule

`default_nettype wire

[rtl/fst_back.sv]
// ----------------------------------------------------------------------------
// fst_back
// Parser state machine and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fst_back
  import fst_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  fifo_stat_t fifo_stat_i,
  input  tok_t       tok_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output res_t       out_res_o
);

  typedef enum logic [6:0] {
    ST_READY     = 7'b0000001,
    ST_ESCAPE    = 7'b0000010,
    ST_MARKER    = 7'b0000100,
    ST_TEXT      = 7'b0001000,
    ST_OPTS      = 7'b0010000,
    ST_OPTS_READ = 7'b0100000,
    ST_FAILED    = 7'b1000000
  } state_e;

  typedef enum logic [1:0] {
    SV_READY = 2'd0,
    SV_TEXT  = 2'd1,
    SV_OPTS  = 2'd2
  } saved_e;

  state_e           st_q, st_d;
  saved_e           sv_q, sv_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic             ov_q, ov_d;
  res_t             res_q;
  res_t             res;
  logic             res_vld;
  state_e           esc_st;
  kind_e            esc_kind;

  assign pop_o = !fifo_stat_i.empty && (!ov_q || out_ready_i);

  // Return target of an escaped character.
  assign esc_st   = (sv_q == SV_OPTS) ? ST_OPTS : ST_TEXT;
  assign esc_kind = (sv_q == SV_OPTS) ? KIND_OPT : KIND_TEXT;

  always_comb begin
    st_d     = st_q;
    sv_d     = sv_q;
    pos_d    = pos_q;
    res_vld  = 1'b0;
    res.kind = KIND_TEXT;
    res.ch   = NUL_CHAR;
    res.code = ERR_NONE;
    res.pos  = '0;
    if (pop_o) begin
      if (tok_i.cls == CLS_END) begin
        if (st_q == ST_TEXT) begin
          res_vld  = 1'b1;
          res.kind = KIND_SEG_END;
        end else if (st_q != ST_READY && st_q != ST_FAILED) begin
          res_vld  = 1'b1;
          res.kind = KIND_ERROR;
          res.code = ERR_END;
          res.pos  = ERR_POS_W'(pos_q);
        end
        st_d  = ST_READY;
        sv_d  = SV_READY;
        pos_d = '0;
      end else begin
        pos_d = pos_q + 1'b1;
        if (st_q != ST_FAILED) begin
          unique case (tok_i.cls)
            CLS_ESC: begin
              unique case (st_q)
                ST_READY: begin sv_d = SV_READY; st_d = ST_ESCAPE; end
                ST_TEXT:  begin sv_d = SV_TEXT;  st_d = ST_ESCAPE; end
                ST_OPTS:  begin sv_d = SV_OPTS;  st_d = ST_ESCAPE; end
                ST_ESCAPE: begin
                  st_d = esc_st; res_vld = 1'b1; res.kind = esc_kind; res.ch = tok_i.ch;
                end
                default: begin
                  st_d = ST_FAILED; res_vld = 1'b1; res.kind = KIND_ERROR;
                  res.code = ERR_ESC; res.pos = ERR_POS_W'(pos_q);
                end
              endcase
            end
            CLS_MARK: begin
              unique case (st_q)
                ST_READY: st_d = ST_MARKER;
                ST_ESCAPE: begin
                  st_d = esc_st; res_vld = 1'b1; res.kind = esc_kind; res.ch = tok_i.ch;
                end
                ST_TEXT: begin
                  st_d = ST_MARKER; res_vld = 1'b1; res.kind = KIND_SEG_END;
                end
                default: begin
                  st_d = ST_FAILED; res_vld = 1'b1; res.kind = KIND_ERROR;
                  res.code = ERR_MARK; res.pos = ERR_POS_W'(pos_q);
                end
              endcase
            end
            CLS_OPEN: begin
              unique case (st_q)
                ST_READY, ST_TEXT: begin
                  st_d = ST_TEXT; res_vld = 1'b1; res.kind = KIND_TEXT; res.ch = tok_i.ch;
                end
                ST_ESCAPE: begin
                  st_d = esc_st; res_vld = 1'b1; res.kind = esc_kind; res.ch = tok_i.ch;
                end
                ST_MARKER: st_d = ST_OPTS;
                default: begin
                  st_d = ST_FAILED; res_vld = 1'b1; res.kind = KIND_ERROR;
                  res.code = ERR_OPEN; res.pos = ERR_POS_W'(pos_q);
                end
              endcase
            end
            CLS_CLOSE: begin
              unique case (st_q)
                ST_READY, ST_TEXT: begin
                  st_d = ST_TEXT; res_vld = 1'b1; res.kind = KIND_TEXT; res.ch = tok_i.ch;
                end
                ST_ESCAPE: begin
                  st_d = esc_st; res_vld = 1'b1; res.kind = esc_kind; res.ch = tok_i.ch;
                end
                ST_OPTS: st_d = ST_OPTS_READ;
                default: begin
                  st_d = ST_FAILED; res_vld = 1'b1; res.kind = KIND_ERROR;
                  res.code = ERR_CLOSE; res.pos = ERR_POS_W'(pos_q);
                end
              endcase
            end
            default: begin
              unique case (st_q)
                ST_READY, ST_TEXT: begin
                  st_d = ST_TEXT; res_vld = 1'b1; res.kind = KIND_TEXT; res.ch = tok_i.ch;
                end
                ST_OPTS: begin
                  res_vld = 1'b1; res.kind = KIND_OPT; res.ch = tok_i.ch;
                end
                ST_MARKER, ST_OPTS_READ: begin
                  st_d = ST_READY; res_vld = 1'b1; res.kind = KIND_ENTRY_END;
                  res.ch = tok_i.ch;
                end
                default: begin
                  st_d = ST_FAILED; res_vld = 1'b1; res.kind = KIND_ERROR;
                  res.code = ERR_CHAR; res.pos = ERR_POS_W'(pos_q);
                end
              endcase
            end
          endcase
        end
      end
    end
  end

  // Load a new result, or drop the held one once it is taken.
  always_comb begin
    ov_d = ov_q;
    if (res_vld)          ov_d = 1'b1;
    else if (out_ready_i) ov_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_READY;
      sv_q  <= SV_READY;
      pos_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      st_q  <= st_d;
      sv_q  <= sv_d;
      pos_q <= pos_d;
      ov_q  <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_vld) res_q <= res;
  end

  assign out_valid_o = ov_q;
  assign out_res_o   = res_q;

endmodule

`default_nettype wire

[rtl/format_string_tokenizer.sv]
// ----------------------------------------------------------------------------
// format_string_tokenizer
// Streams a format string in, one character per transfer, and streams out
// text characters, option characters, segment ends, entry ends and errors.
// ----------------------------------------------------------------------------
//
//  channel   direction  tdata (low bit up)                       tuser
//  --------  ---------  ---------------------------------------  -----------
//  s_axis    in         char_in[7:0]                             func[0]
//  m_axis    out        char_out[7:0], error_code[10:8],         kind[2:0]
//                       error_position[26:11], zero[31:27]
//  cfg       in         write enable, index, 8-bit character     -
//
// One character per cycle sustained while the output is ready. An accepted
// character passes through the input register and the token queue; the
// parser decodes the queue head and loads the output register at the pop
// edge. The parser state update is the per-item loop; the four-entry queue
// lets the input keep flowing while the output stalls, until the queue and
// the input register fill. Reset clears the special characters to their
// defaults, the parser to ready and the position to zero; there is no
// clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module format_string_tokenizer
  import fst_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // configuration writes
  input  wire logic                   cfg_we_i,
  input  wire logic [1:0]             cfg_idx_i,
  input  wire logic [CHAR_W-1:0]      cfg_data_i,
  // input characters
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // char_in[7:0]
  input  wire logic [0:0]             s_axis_tuser,   // func[0]
  // results
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,   // char_out, error_code, error_position
  output logic [2:0]                  m_axis_tuser    // kind[2:0]
);

  fifo_stat_t fifo_stat;
  logic       push;
  logic       pop;
  tok_t       push_tok;
  tok_t       pop_tok;
  res_t       res;

  // Front: hold the special characters, classify each accepted character.
  fst_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_e'(cfg_idx_i)),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_end_i    (s_axis_tuser[0]),
    .in_char_i   (s_axis_tdata[CHAR_W-1:0]),
    .fifo_stat_i (fifo_stat),
    .push_o      (push),
    .push_tok_o  (push_tok)
  );

  // Queue: decouple classification from parsing.
  fst_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_tok_i (push_tok),
    .pop_i      (pop),
    .pop_tok_o  (pop_tok),
    .stat_o     (fifo_stat)
  );

  // Back: advance the parser and register the result.
  fst_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fifo_stat_i (fifo_stat),
    .tok_i       (pop_tok),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res)
  );

  // Pack the result fields, lowest first, zero-filled to whole bytes.
  assign m_axis_tdata = OUT_TDATA_W'({res.pos, res.code, res.ch});
  assign m_axis_tuser = res.kind;

endmodule

`default_nettype wire

[rtl/fst_checker.sv]
// ----------------------------------------------------------------------------
// fst_checker
// Port-level checks on the tokenizer result stream.
// ----------------------------------------------------------------------------
`default_nettype none

`include "format_string_tokenizer_assert.svh"

module fst_checker
  import fst_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  input  wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  wire logic [2:0]             m_axis_tuser
);

  logic is_err;
  logic is_seg_end;

  assign is_err     = (m_axis_tuser == KIND_ERROR);
  assign is_seg_end = (m_axis_tuser == KIND_SEG_END);

  // A stalled result holds.
  `FST_ASSERT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

  // Only errors carry a code and a position.
  `FST_ASSERT(a_no_err_fields, clk_i, rst_ni, m_axis_tvalid && !is_err |-> m_axis_tdata[26:8] == '0, "error fields set on a non-error result")

  // An error always names its cause.
  `FST_ASSERT(a_err_code, clk_i, rst_ni, m_axis_tvalid && is_err |-> m_axis_tdata[10:8] != ERR_NONE && m_axis_tdata[7:0] == NUL_CHAR, "error without code")

  // A segment end carries no character.
  `FST_ASSERT(a_seg_end, clk_i, rst_ni, m_axis_tvalid && is_seg_end |-> m_axis_tdata == '0, "segment end carries data")

  // Nothing is offered while in reset.
  `FST_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !m_axis_tvalid, "result offered during reset")

endmodule

bind format_string_tokenizer fst_checker u_fst_checker (.*);

`default_nettype wire
